>>> rtl/optimal_page_replacement_unit_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef OPTIMAL_PAGE_REPLACEMENT_UNIT_ASSERT_SVH
`define OPTIMAL_PAGE_REPLACEMENT_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define OPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The condition must never be true outside reset.
`define OPR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

>>> rtl/opr_pkg.sv
`default_nettype none
package opr_pkg;

   localparam int DEF_MAX_FRAMES = 64;
   localparam int DEF_PAGE_SPACE = 4096;

   localparam int IDX_W_MAX   = 10;
   localparam int PAGE_W_MAX  = 16;
   localparam int KEY_W       = 32;
   localparam int TRACE_W     = 31;
   localparam int FC_W        = 7;
   localparam int HP_W        = 12;
   localparam int CNT_W       = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 80;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_COUNT  = 2'd0,
      CSR_TRACE_LENGTH = 2'd1,
      CSR_HIGHEST_PAGE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   // Running search result handed from one slot cell to the next.
   typedef struct packed {
      logic                  active;
      logic                  hit_found;
      logic [IDX_W_MAX-1:0]  hit_idx;
      logic                  free_found;
      logic [IDX_W_MAX-1:0]  free_idx;
      logic                  best_found;
      logic [IDX_W_MAX-1:0]  best_idx;
      logic [KEY_W-1:0]      best_key;
      logic [PAGE_W_MAX-1:0] best_page;
   } scan_type;

   // Broadcast slot update from the control logic.
   typedef struct packed {
      logic                  en;
      logic [IDX_W_MAX-1:0]  idx;
      logic [PAGE_W_MAX-1:0] page;
      logic [KEY_W-1:0]      key;
   } slot_wr_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

endpackage
`default_nettype wire

>>> rtl/optimal_page_replacement_unit.sv
`default_nettype none
// Optimal page replacement unit.
// Each req transaction carries one page reference: page in tdata[15:0] and its
// next-use position in tdata[46:16]. Each reference yields exactly one rsp
// transaction with hit, range error, first touch, eviction and running totals.
// Resident pages live in a row of MAX_FRAMES slot cells. A reference walks the
// row one cell per cycle, collecting the matching slot, the lowest free slot
// and the largest key. The next reference can be accepted in the same cycle
// as the result of the last one appears.
// Out-of-range pages skip the scan and change no state.
// One result may wait in the output register while the next reference is
// scanned; a stalled receiver holds the unit only once a second result is due.
// After reset the first-touch memory is cleared, one page a cycle, over all
// PAGE_SPACE pages; req_tready stays low meanwhile while csr writes are taken.
// The csr channel is always ready and must only be written while idle.
module optimal_page_replacement_unit #(
   parameter int MAX_FRAMES = opr_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_SPACE = opr_pkg::DEF_PAGE_SPACE
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // page[15:0], next_position[46:16], zero[47]
   input  wire logic [opr_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // hit[0], range_error[1], first_touch[2], evicted_valid[3],
   // evicted_page[15:4], fault_total[47:16], cold_total[79:48]
   output logic [opr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [opr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [opr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import opr_pkg::*;

   `include "optimal_page_replacement_unit_assert.svh"

   localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PAGE_W    = $clog2(PAGE_SPACE);
   localparam int CNTF_W    = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W     = (CNTF_W > FC_W) ? CNTF_W : FC_W;
   localparam int RESET_LIM = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;

   function automatic logic [LIM_W-1:0] clamp_frames(input logic [FC_W-1:0] v);
      logic [LIM_W-1:0] w;
      w = LIM_W'(v);
      if (w == '0) return LIM_W'(1);
      if (w > LIM_W'(MAX_FRAMES)) return LIM_W'(MAX_FRAMES);
      return w;
   endfunction

   state_type          state_ff, state_in;
   logic [15:0]        page_ff, page_in;
   logic [TRACE_W-1:0] next_ff, next_in;
   logic               range_ff, range_in;
   scan_type           result_ff, result_in;
   logic               seen_rd_ff;
   logic [PAGE_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [TRACE_W-1:0] trace_length_ff;
   logic [HP_W-1:0]    highest_page_ff;
   logic [CNTF_W-1:0]  free_ff, free_in;
   logic [CNTF_W-1:0]  used_ff, used_in;
   logic [TRACE_W-1:0] ref_idx_ff, ref_idx_in;
   logic [CNT_W-1:0]   fault_ff, fault_in;
   logic [CNT_W-1:0]   cold_ff, cold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                seen_mem [PAGE_SPACE];
   logic                seen_we;
   logic [PAGE_W-1:0]   seen_addr;
   logic                seen_wd;

   scan_type            chain_c [MAX_FRAMES+1];
   slot_wr_type         slot_wr;

   logic                accept;
   logic [15:0]         req_page;
   logic [TRACE_W-1:0]  req_next;
   logic                out_of_range;
   logic                rsp_free;
   logic [KEY_W-1:0]    new_key;
   logic [TRACE_W-1:0]  key_base;
   logic [IDX_W-1:0]    slot_sel;
   logic                ev_valid;
   logic [31:0]         ev_page_w;
   logic [LIM_W-1:0]    csr_lim;
   logic [LIM_W-1:0]    used_w;
   logic [PAGE_W-1:0]   query_page;

   assign req_page     = req_tdata[15:0];
   assign req_next     = req_tdata[46:16];
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign out_of_range = (req_page > 16'(highest_page_ff)) ||
                         (17'(req_page) >= 17'(PAGE_SPACE));
   assign rsp_free     = !rsp_valid_ff || rsp_tready;
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   // The first cell compares in the accepting cycle, before page_ff is loaded.
   assign query_page = accept ? req_page[PAGE_W-1:0] : page_ff[PAGE_W-1:0];

   assign key_base = (next_ff == '0) ? trace_length_ff : next_ff;
   assign new_key  = KEY_W'(key_base) + KEY_W'(ref_idx_ff);

   always_comb begin
      chain_c[0]        = '0;
      chain_c[0].active = accept && !out_of_range;
   end

   for (genvar s = 0; s < MAX_FRAMES; s++) begin : g_slot
      opr_cell #(
         .SLOT   (s),
         .PAGE_W (PAGE_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query_page (query_page),
         .chain_prev (chain_c[s]),
         .chain_next (chain_c[s+1]),
         .wr         (slot_wr)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         free_ff       <= CNTF_W'(RESET_LIM);
         used_ff       <= '0;
         ref_idx_ff    <= '0;
         fault_ff      <= '0;
         cold_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         free_ff       <= free_in;
         used_ff       <= used_in;
         ref_idx_ff    <= ref_idx_in;
         fault_ff      <= fault_in;
         cold_ff       <= cold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      next_ff     <= next_in;
      range_ff    <= range_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_length_ff <= TRACE_W'(1048576);
         highest_page_ff <= HP_W'(4095);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRACE_LENGTH: trace_length_ff <= csr_data[TRACE_W-1:0];
            CSR_HIGHEST_PAGE: highest_page_ff <= csr_data[HP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_addr] <= seen_wd;
      end
      if (accept) begin
         seen_rd_ff <= seen_mem[req_page[PAGE_W-1:0]];
      end
   end

   assign csr_lim = clamp_frames(csr_data[FC_W-1:0]);
   assign used_w  = LIM_W'(used_ff);

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      next_in       = next_ff;
      range_in      = range_ff;
      result_in     = result_ff;
      clear_addr_in = clear_addr_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      ref_idx_in    = ref_idx_ff;
      fault_in      = fault_ff;
      cold_in       = cold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      seen_we       = 1'b0;
      seen_addr     = page_ff[PAGE_W-1:0];
      seen_wd       = 1'b1;
      slot_wr       = '0;
      slot_sel      = '0;
      ev_valid      = 1'b0;
      ev_page_w     = '0;

      if (csr_valid && csr_ready && csr_index == CSR_FRAME_COUNT) begin
         free_in = (csr_lim > used_w) ? CNTF_W'(csr_lim - used_w) : '0;
      end

      case (state_ff)
         ST_CLEAR: begin
            seen_we       = 1'b1;
            seen_addr     = clear_addr_ff;
            seen_wd       = 1'b0;
            clear_addr_in = clear_addr_ff + PAGE_W'(1);
            if (clear_addr_ff == PAGE_W'(PAGE_SPACE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               page_in  = req_page;
               next_in  = req_next;
               range_in = out_of_range;
               state_in = out_of_range ? ST_COMMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain_c[MAX_FRAMES].active) begin
               result_in = chain_c[MAX_FRAMES];
               state_in  = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (range_ff) begin
                  rsp_data_in = {cold_ff, fault_ff, 12'd0, 1'b0, 1'b0, 1'b1, 1'b0};
               end else begin
                  if (!seen_rd_ff) begin
                     cold_in = sat_inc(cold_ff);
                     seen_we = 1'b1;
                  end
                  if (result_ff.hit_found) begin
                     slot_sel = result_ff.hit_idx[IDX_W-1:0];
                  end else begin
                     fault_in = sat_inc(fault_ff);
                     if (free_ff != '0 && result_ff.free_found) begin
                        slot_sel = result_ff.free_idx[IDX_W-1:0];
                        free_in  = free_ff - CNTF_W'(1);
                        used_in  = used_ff + CNTF_W'(1);
                     end else if (result_ff.best_found) begin
                        slot_sel  = result_ff.best_idx[IDX_W-1:0];
                        ev_valid  = 1'b1;
                        ev_page_w = 32'(result_ff.best_page);
                     end else begin
                        // Nothing resident and no free frame: use the first slot.
                        slot_sel = '0;
                        used_in  = used_ff + CNTF_W'(1);
                     end
                  end
                  slot_wr.en   = 1'b1;
                  slot_wr.idx  = IDX_W_MAX'(slot_sel);
                  slot_wr.page = page_ff;
                  slot_wr.key  = new_key;
                  ref_idx_in   = ref_idx_ff + TRACE_W'(1);
                  rsp_data_in  = {cold_in, fault_in, ev_page_w[11:0], ev_valid,
                                  !seen_rd_ff, 1'b0, result_ff.hit_found};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `OPR_ASSERT_NEVER(a_scan_end_state, clock, reset,
      (chain_c[MAX_FRAMES].active && state_ff != ST_SCAN), "scan ended outside scan state")
   `OPR_ASSERT_NEVER(a_frame_budget, clock, reset,
      ((LIM_W+1)'(used_ff) + (LIM_W+1)'(free_ff) > (LIM_W+1)'(MAX_FRAMES)),
      "used and free frames exceed the slot count")
   `OPR_ASSERT_NEXT(a_accept_moves, clock, reset, accept,
      (state_ff == ST_SCAN || state_ff == ST_COMMIT), "accepted reference not in flight")

endmodule
`default_nettype wire

>>> rtl/opr_cell.sv
`default_nettype none
module opr_cell #(
   parameter int SLOT   = 0,
   parameter int PAGE_W = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [PAGE_W-1:0]    query_page,
   input  wire opr_pkg::scan_type    chain_prev,
   output opr_pkg::scan_type         chain_next,
   input  wire opr_pkg::slot_wr_type wr
);
   import opr_pkg::*;

   logic              valid_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [KEY_W-1:0]  key_ff;
   scan_type          scan_ff, scan_in;

   always_comb begin
      scan_in = chain_prev;
      if (!chain_prev.hit_found && valid_ff && page_ff == query_page) begin
         scan_in.hit_found = 1'b1;
         scan_in.hit_idx   = IDX_W_MAX'(SLOT);
      end
      if (!chain_prev.free_found && !valid_ff) begin
         scan_in.free_found = 1'b1;
         scan_in.free_idx   = IDX_W_MAX'(SLOT);
      end
      // Strict compare keeps the lowest slot among equal keys.
      if (valid_ff && (!chain_prev.best_found || key_ff > chain_prev.best_key)) begin
         scan_in.best_found = 1'b1;
         scan_in.best_idx   = IDX_W_MAX'(SLOT);
         scan_in.best_key   = key_ff;
         scan_in.best_page  = PAGE_W_MAX'(page_ff);
      end
      if (!chain_prev.active) begin
         scan_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         scan_ff <= scan_in;
         if (wr.en && wr.idx == IDX_W_MAX'(SLOT)) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.idx == IDX_W_MAX'(SLOT)) begin
         page_ff <= wr.page[PAGE_W-1:0];
         key_ff  <= wr.key;
      end
   end

   assign chain_next = scan_ff;

endmodule
`default_nettype wire

>>> tb/tb_optimal_page_replacement_unit.sv
`default_nettype none
module tb_optimal_page_replacement_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import opr_pkg::*;

   localparam int FRAMES      = 64;
   localparam int PAGES       = 4096;
   localparam int DRAIN_WAIT  = 80;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic        hit;
      logic        range_error;
      logic        first_touch;
      logic        evicted_valid;
      logic [11:0] evicted_page;
      logic [31:0] fault_total;
      logic [31:0] cold_total;
   } page_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_COUNT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   optimal_page_replacement_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Shadow replacement state.
   logic [6:0]  frame_count_reg;
   logic [30:0] trace_length_reg;
   logic [11:0] highest_page_reg;
   bit          resident_pages[PAGES];
   bit          seen_pages[PAGES];
   logic [11:0] slot_page[FRAMES];
   logic [31:0] slot_key[FRAMES];
   bit          slot_used[FRAMES];
   int unsigned free_count;
   logic [30:0] ref_index;
   logic [31:0] fault_count;
   logic [31:0] cold_count;

   page_verdict_type expected_verdicts[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_idle = 1'b0;
   int  pool[16];
   int  pool_size = 4;

   function automatic int unsigned frame_limit();
      if (frame_count_reg == 0) return 1;
      if (frame_count_reg > FRAMES) return FRAMES;
      return frame_count_reg;
   endfunction

   function automatic logic [31:0] sat_plus(logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function automatic void shadow_reset();
      frame_count_reg = 7'd64;
      trace_length_reg = 31'd1048576;
      highest_page_reg = 12'd4095;
      foreach (resident_pages[i]) begin
         resident_pages[i] = 0;
         seen_pages[i] = 0;
      end
      foreach (slot_used[i]) begin
         slot_used[i] = 0;
         slot_page[i] = '0;
         slot_key[i] = '0;
      end
      free_count = frame_limit();
      ref_index = '0;
      fault_count = '0;
      cold_count = '0;
   endfunction

   function automatic page_verdict_type belady_predict(logic [15:0] page, logic [30:0] next);
      page_verdict_type v;
      logic [31:0] key;
      logic [31:0] best;
      int slot;
      v = '0;
      slot = -1;
      best = '0;
      if (page > highest_page_reg || page >= PAGES) begin
         v.range_error = 1'b1;
         v.fault_total = fault_count;
         v.cold_total = cold_count;
         return v;
      end
      if (!seen_pages[page]) begin
         v.first_touch = 1'b1;
         seen_pages[page] = 1;
         cold_count = sat_plus(cold_count);
      end
      key = {1'b0, (next == 0) ? trace_length_reg : next} + {1'b0, ref_index};
      if (resident_pages[page]) begin
         v.hit = 1'b1;
         for (int s = 0; s < FRAMES; s++)
            if (slot_used[s] && slot_page[s] == page[11:0]) begin
               slot = s;
               break;
            end
      end else begin
         fault_count = sat_plus(fault_count);
         if (free_count != 0)
            for (int s = 0; s < FRAMES; s++)
               if (!slot_used[s]) begin
                  slot = s;
                  break;
               end
         if (slot < 0) begin
            // Largest key wins; strict compare keeps the lowest slot on ties.
            for (int s = 0; s < FRAMES; s++)
               if (slot_used[s] && (slot < 0 || slot_key[s] > best)) begin
                  slot = s;
                  best = slot_key[s];
               end
            v.evicted_valid = 1'b1;
            v.evicted_page = slot_page[slot];
            resident_pages[slot_page[slot]] = 0;
         end else begin
            free_count--;
         end
         resident_pages[page] = 1;
         slot_used[slot] = 1;
         slot_page[slot] = page[11:0];
      end
      slot_key[slot] = key;
      ref_index = ref_index + 31'd1;
      v.fault_total = fault_count;
      v.cold_total = cold_count;
      return v;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("optimal_page_replacement_unit verification failed");
         $finish;
      end
   end

   task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         error_count++;
      end
   endtask

   // Result side: random stall before each transaction unless no_idle is set, then compare.
   initial begin
      int stall;
      page_verdict_type exp;
      page_verdict_type act;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         act.hit = rsp_tdata[0];
         act.range_error = rsp_tdata[1];
         act.first_touch = rsp_tdata[2];
         act.evicted_valid = rsp_tdata[3];
         act.evicted_page = rsp_tdata[15:4];
         act.fault_total = rsp_tdata[47:16];
         act.cold_total = rsp_tdata[79:48];
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result transaction 0x%0h", rsp_tdata);
            error_count++;
         end else begin
            exp = expected_verdicts.pop_front();
            check_field("hit", exp.hit, act.hit);
            check_field("range_error", exp.range_error, act.range_error);
            check_field("first_touch", exp.first_touch, act.first_touch);
            check_field("evicted_valid", exp.evicted_valid, act.evicted_valid);
            check_field("evicted_page", exp.evicted_page, act.evicted_page);
            check_field("fault_total", exp.fault_total, act.fault_total);
            check_field("cold_total", exp.cold_total, act.cold_total);
         end
      end
   end

   // Called right after a rising edge; leaves req_tvalid high after acceptance.
   task automatic send_reference(logic [15:0] page, logic [30:0] next);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, next, page};
      do @(posedge clock); while (!req_tready);
      expected_verdicts.push_back(belady_predict(page, next));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [30:0] value);
      int unsigned used;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_COUNT: begin
            used = 0;
            frame_count_reg = value[6:0];
            foreach (slot_used[i]) if (slot_used[i]) used++;
            free_count = (frame_limit() > used) ? frame_limit() - used : 0;
         end
         CSR_TRACE_LENGTH: trace_length_reg = value;
         CSR_HIGHEST_PAGE: highest_page_reg = value[11:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [30:0] frames, logic [30:0] trace, logic [30:0] highest);
      drain();
      write_register(CSR_FRAME_COUNT, frames);
      write_register(CSR_TRACE_LENGTH, trace);
      write_register(CSR_HIGHEST_PAGE, highest);
   endtask

   task automatic test_directed();
      configure(31'd2, 31'h7FFF_FFFF, 31'd4095);
      send_reference(16'd0, 31'd0);
      send_reference(16'd4095, 31'h7FFF_FFFF);
      send_reference(16'd4096, 31'd5);
      send_reference(16'hFFFF, 31'd5);
      send_reference(16'd0, 31'd3);          // hit
      send_reference(16'd7, 31'd1);          // eviction of the far page
      // Equal keys: next + index matches across two pages.
      send_reference(16'd8, 31'd20);
      send_reference(16'd9, 31'd19);
      send_reference(16'd10, 31'd1);
      send_reference(16'd9, 31'd0);
      configure(31'd1, 31'd1, 31'd0);
      send_reference(16'd1, 31'd1);          // above the highest page
      send_reference(16'd0, 31'd0);
      send_reference(16'd0, 31'd2);
      configure(31'd0, 31'd100, 31'd4095);   // zero frames acts as one
      send_reference(16'd3, 31'd4);
      send_reference(16'd4, 31'd0);
      send_reference(16'd4, 31'd9);
      configure(31'd100, 31'd100, 31'd4095); // above the frame maximum
      send_reference(16'h0AAA, 31'h2AAA_AAAA);
      send_reference(16'h0555, 31'h5555_5555);
      send_reference(16'h0AAA, 31'd0);
      send_reference(16'h8000, 31'd0);
   endtask

   task automatic test_random(int count, logic [30:0] frames, logic [30:0] trace,
                              logic [30:0] highest, bit quiet);
      int r;
      logic [15:0] page;
      logic [30:0] next;
      configure(frames, trace, highest);
      no_idle = quiet;
      pool_size = $urandom_range(2, 16);
      foreach (pool[i]) pool[i] = int'($urandom_range(0, highest));
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 80) page = 16'(pool[$urandom_range(0, pool_size - 1)]);
         else if (r < 90) page = 16'($urandom_range(0, highest));
         else page = 16'($urandom());
         r = $urandom_range(0, 3);
         if (r == 0) next = '0;
         else if (r == 3) next = 31'($urandom());
         else next = 31'($urandom_range(1, 300));
         send_reference(page, next);
      end
      no_idle = 1'b0;
   endtask

   // Shrinking the frame count with pages resident must evict, not refill.
   task automatic test_shrink();
      test_random(120, 31'd12, 31'd500, 31'd4095, 1'b0);
      configure(31'd3, 31'd500, 31'd4095);
      test_random(120, 31'd3, 31'd500, 31'd4095, 1'b0);
   endtask

   initial begin
      shadow_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(240, 31'd4, 31'd1000, 31'd4095, 1'b0);
      test_random(200, 31'd1, 31'd1, 31'd63, 1'b1);
      test_random(200, 31'd0, 31'h7FFF_FFFF, 31'd4095, 1'b0);
      test_random(200, 31'd64, 31'd1048576, 31'd4095, 1'b0);
      test_random(200, 31'd100, 31'd50, 31'd200, 1'b1);
      test_random(150, 31'd8, 31'h7FFF_FFFF, 31'd4095, 1'b0);
      test_shrink();
      drain();
      if (error_count == 0) begin
         $display("optimal_page_replacement_unit verification clean");
      end else begin
         $display("optimal_page_replacement_unit verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
